// ===== rtl/imu_tilt_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU tilt filter package
// Beat types, register indexes, arithmetic constants and the arctangent table.
// ----------------------------------------------------------------------------
package imu_tilt_pkg;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
	} sample_t;

	typedef struct packed {
		logic signed [13:0] svm;
		logic signed [15:0] angle_x;
		logic               offsets_ready;
		logic               calib_done;
	} result_t;

	localparam logic [1:0] CFG_CALIB_COUNT  = 2'd0;
	localparam logic [1:0] CFG_STEP_TIME    = 2'd1;
	localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd2;

	localparam logic KIND_CALIB = 1'b0;

	localparam int MAX_CALIB    = 1024;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_W        = 43;
	localparam int SQRT_STEPS   = 26;

	// Arctangent of 2^-i in 1/65536 degree.
	function automatic logic [22:0] atan_tab(input logic [4:0] i);
		logic [22:0] v;
		case (i)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/imu_tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// IMU tilt complementary filter
// Accelerometer bias calibration, vector magnitude and filtered x tilt angle.
// ----------------------------------------------------------------------------
// Usage: samples arrive as beats on the sample channel (valid/ready) and each
// gives exactly one beat on the result channel. A calibration sample adds to
// the bias sums; the sample that completes a run computes the four offsets.
// A measurement sample returns the magnitude minus 1 g and the updated angle.
// Registers go through the cfg channel (index, data); the user writes only while
// idle, unchecked by the block. cfg_ready is always high; unknown indexes ignored.
// A measurement runs the 43-step restoring divider beside the 26-step square
// root and the 16-step CORDIC. A calibration sample goes straight to the
// output register, or, when it ends a run, first through four divisions in
// the same divider, one per axis.
// One sample is in work at a time; the next is taken once the result sits in
// the output register, even if the receiver has not yet taken it. If the
// receiver stalls, the following result waits until the register is free.
// After reset all sums, offsets and the angle are zero and the registers
// hold their default values.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  imu_tilt_pkg::sample_t sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output imu_tilt_pkg::result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_M0     = 4'd1;
	localparam logic [3:0] ST_M1     = 4'd2;
	localparam logic [3:0] ST_M2     = 4'd3;
	localparam logic [3:0] ST_M3     = 4'd4;
	localparam logic [3:0] ST_M4     = 4'd5;
	localparam logic [3:0] ST_ITER   = 4'd6;
	localparam logic [3:0] ST_MAG    = 4'd7;
	localparam logic [3:0] ST_SVM    = 4'd8;
	localparam logic [3:0] ST_B1     = 4'd9;
	localparam logic [3:0] ST_B2     = 4'd10;
	localparam logic [3:0] ST_CSTART = 4'd11;
	localparam logic [3:0] ST_CITER  = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	localparam int DW = imu_tilt_pkg::DIV_W;

	logic [3:0]  state_q;
	logic [5:0]  cnt_q;
	logic [10:0] calib_count_q;
	logic [15:0] step_time_q;
	logic [15:0] blend_q;

	logic signed [27:0] sums_q [4];
	logic signed [16:0] offs_q [4];
	logic [10:0] seen_q;
	logic signed [15:0] tilt_q;
	logic ready_flag_q;
	logic done_q;
	logic [1:0] ax_q;

	logic signed [17:0] c_q [4];
	logic [35:0] s_q;
	logic signed [13:0] svm_q;
	logic signed [46:0] tot_q;

	// Shared multiplier, registered output.
	logic signed [27:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [45:0] prod_q;

	// Divider
	logic [DW-1:0] dd_q;
	logic [17:0]   dsr_q;
	logic [17:0]   rem_q;
	logic          dneg_q;
	logic [18:0]   div_r2;
	logic          div_ge;

	// Square root
	logic [51:0] rad_q;
	logic [27:0] srem_q;
	logic [25:0] root_q;
	logic [29:0] sq_r2;
	logic [29:0] sq_trial;
	logic        sq_ge;

	// CORDIC
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [25:0] ang_q;
	logic               cz_q;

	logic [10:0] n_eff;
	logic [10:0] seen_next;
	logic signed [27:0] sum_next [4];
	logic signed [17:0] a_in [4];

	logic        g_neg;
	logic [33:0] g_abs;
	logic signed [26:0] gyro_term;
	logic signed [27:0] pred;
	logic signed [25:0] acc_ang;

	logic signed [16:0] svm_raw;
	logic [36:0] svm_t;

	logic signed [46:0] tot;
	logic [46:0] tot_abs;
	logic [20:0] tot_r;
	logic signed [15:0] blend_angle;
	logic signed [18:0] zsum;
	logic signed [18:0] zq;
	logic signed [15:0] zero_angle;

	logic signed [27:0] cal_sum;
	logic [27:0] cal_abs;

	logic out_free;
	logic result_valid_q;
	imu_tilt_pkg::result_t result_q;

	assign sample_ready = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	always_comb begin
		if (calib_count_q == 11'd0)
			n_eff = 11'd1;
		else if (calib_count_q > 11'(imu_tilt_pkg::MAX_CALIB))
			n_eff = 11'(imu_tilt_pkg::MAX_CALIB);
		else
			n_eff = calib_count_q;
	end

	always_comb begin
		a_in[0] = 18'(sample.accel_x);
		a_in[1] = 18'(sample.accel_y);
		a_in[2] = 18'(sample.accel_z);
		a_in[3] = 18'(sample.gyro_x);
		for (int i = 0; i < 4; i++)
			sum_next[i] = sums_q[i] + 28'(a_in[i]);
		sum_next[2] = sums_q[2] + 28'(a_in[2]) - 28'sd8192;
		seen_next = seen_q + 11'd1;
	end

	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_a = 28'(c_q[0]);
				mul_b = c_q[0];
			end
			ST_M1: begin
				mul_a = 28'(c_q[1]);
				mul_b = c_q[1];
			end
			ST_M2: begin
				mul_a = 28'(c_q[2]);
				mul_b = c_q[2];
			end
			ST_M3: begin
				mul_a = 28'(c_q[3]);
				mul_b = $signed({2'b00, step_time_q});
			end
			ST_MAG: begin
				mul_a = $signed({2'b00, root_q});
				mul_b = 18'sd981;
			end
			ST_SVM: begin
				mul_a = pred;
				mul_b = $signed({2'b00, blend_q});
			end
			ST_B1: begin
				mul_a = 28'(acc_ang);
				mul_b = $signed(18'd65536 - {2'b00, blend_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	always_comb begin
		div_r2   = {rem_q, dd_q[DW-1]};
		div_ge   = (div_r2 >= {1'b0, dsr_q});
		sq_r2    = {srem_q, rad_q[51:50]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_r2 >= sq_trial);
	end

	always_comb begin
		g_neg     = prod_q[45];
		g_abs     = g_neg ? 34'(-prod_q) : 34'(prod_q);
		gyro_term = dneg_q ? -$signed(dd_q[26:0]) : $signed(dd_q[26:0]);
		pred      = (28'(tilt_q) <<< 10) + 28'(gyro_term);
		acc_ang   = cz_q ? 26'sd0 : ang_q;
		cal_sum   = sums_q[ax_q];
		cal_abs   = cal_sum[27] ? 28'(-cal_sum) : 28'(cal_sum);
	end

	always_comb begin
		svm_t   = prod_q[36:0] + 37'd1048576;
		svm_raw = $signed({1'b0, svm_t[36:21]}) - 17'sd981;
		if (svm_raw > 17'sd6000)
			svm_raw = 17'sd6000;
	end

	always_comb begin
		tot     = tot_q + 47'(prod_q);
		tot_abs = tot[46] ? 47'(-tot) : 47'(tot);
		tot_r   = 21'((tot_abs + 47'd33554432) >> 26);
		if (!tot[46])
			blend_angle = (tot_r > 21'd32767) ? 16'sh7fff : $signed(tot_r[15:0]);
		else
			blend_angle = (tot_r > 21'd32768) ? 16'sh8000 : -$signed(tot_r[15:0]);
		zq   = dneg_q ? -$signed({1'b0, dd_q[17:0]}) : $signed({1'b0, dd_q[17:0]});
		zsum = 19'(tilt_q) + zq;
		if (zsum > 19'sd32767)
			zero_angle = 16'sh7fff;
		else if (zsum < -19'sd32768)
			zero_angle = 16'sh8000;
		else
			zero_angle = zsum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_count_q <= 11'd500;
			step_time_q   <= 16'd10000;
			blend_q       <= 16'd64749;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				imu_tilt_pkg::CFG_CALIB_COUNT:  calib_count_q <= cfg_data[10:0];
				imu_tilt_pkg::CFG_STEP_TIME:    step_time_q   <= cfg_data;
				imu_tilt_pkg::CFG_BLEND_WEIGHT: blend_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			seen_q         <= '0;
			tilt_q         <= '0;
			ready_flag_q   <= 1'b0;
			done_q         <= 1'b0;
			ax_q           <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= '0;
				offs_q[i] <= '0;
			end
		end else begin
			// In the output state the result register is handled below.
			if (result_valid_q && result_ready && state_q != ST_OUT)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						done_q <= 1'b0;
						svm_q  <= '0;
						ax_q   <= '0;
						if (sample.kind == imu_tilt_pkg::KIND_CALIB) begin
							for (int i = 0; i < 4; i++)
								sums_q[i] <= sum_next[i];
							seen_q <= seen_next;
							state_q <= (seen_next >= n_eff) ? ST_CSTART : ST_OUT;
						end else begin
							for (int i = 0; i < 4; i++)
								c_q[i] <= a_in[i] - 18'(offs_q[i]);
							state_q <= ST_M0;
						end
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					s_q     <= prod_q[35:0];
					state_q <= ST_M2;
				end
				ST_M2: begin
					s_q     <= s_q + prod_q[35:0];
					state_q <= ST_M3;
				end
				ST_M3: begin
					s_q     <= s_q + prod_q[35:0];
					state_q <= ST_M4;
				end
				ST_M4: begin
					// prod_q now holds rate times step time.
					rad_q  <= {s_q, 16'd0};
					srem_q <= '0;
					root_q <= '0;
					rem_q  <= '0;
					dneg_q <= g_neg;
					if (s_q != 36'd0) begin
						dd_q  <= {g_abs, 9'd0} + DW'(62500);
						dsr_q <= 18'd125000;
					end else begin
						dd_q  <= DW'(g_abs) + DW'(125000);
						dsr_q <= 18'd250000;
					end
					cz_q <= (c_q[1] == 18'sd0) && (c_q[2] == 18'sd0);
					if (c_q[2] < 0) begin
						ang_q <= (c_q[1] >= 0) ? 26'sd11796480 : -26'sd11796480;
						cx_q  <= 34'(-c_q[2]) <<< 12;
						cy_q  <= 34'(-c_q[1]) <<< 12;
					end else begin
						ang_q <= '0;
						cx_q  <= 34'(c_q[2]) <<< 12;
						cy_q  <= 34'(c_q[1]) <<< 12;
					end
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					rem_q <= div_ge ? 18'(div_r2 - {1'b0, dsr_q}) : div_r2[17:0];
					dd_q  <= {dd_q[DW-2:0], div_ge};
					if (cnt_q < 6'(imu_tilt_pkg::SQRT_STEPS)) begin
						srem_q <= sq_ge ? 28'(sq_r2 - sq_trial) : sq_r2[27:0];
						root_q <= {root_q[24:0], sq_ge};
						rad_q  <= {rad_q[49:0], 2'b00};
					end
					if (cnt_q < 6'(imu_tilt_pkg::CORDIC_STEPS)) begin
						if (cy_q > 0) begin
							cx_q  <= cx_q + (cy_q >>> cnt_q[4:0]);
							cy_q  <= cy_q - (cx_q >>> cnt_q[4:0]);
							ang_q <= ang_q + $signed({3'b000, imu_tilt_pkg::atan_tab(cnt_q[4:0])});
						end else begin
							cx_q  <= cx_q - (cy_q >>> cnt_q[4:0]);
							cy_q  <= cy_q + (cx_q >>> cnt_q[4:0]);
							ang_q <= ang_q - $signed({3'b000, imu_tilt_pkg::atan_tab(cnt_q[4:0])});
						end
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DW - 1))
						state_q <= ST_MAG;
				end
				ST_MAG: state_q <= ST_SVM;
				ST_SVM: begin
					svm_q   <= svm_raw[13:0];
					state_q <= ST_B1;
				end
				ST_B1: begin
					tot_q   <= 47'(prod_q);
					state_q <= ST_B2;
				end
				ST_B2: begin
					tilt_q  <= (s_q != 36'd0) ? blend_angle : zero_angle;
					state_q <= ST_OUT;
				end
				ST_CSTART: begin
					dd_q    <= DW'(cal_abs) + DW'(n_eff >> 1);
					dsr_q   <= 18'(n_eff);
					rem_q   <= '0;
					dneg_q  <= cal_sum[27];
					cnt_q   <= '0;
					state_q <= ST_CITER;
				end
				ST_CITER: begin
					if (cnt_q == 6'(DW)) begin
						// Quotient is complete: store this axis and move on.
						offs_q[ax_q] <= dneg_q ? -$signed(dd_q[16:0]) : $signed(dd_q[16:0]);
						sums_q[ax_q] <= '0;
						ax_q <= ax_q + 2'd1;
						if (ax_q == 2'd3) begin
							seen_q       <= '0;
							ready_flag_q <= 1'b1;
							done_q       <= 1'b1;
							state_q      <= ST_OUT;
						end else begin
							state_q <= ST_CSTART;
						end
					end else begin
						rem_q <= div_ge ? 18'(div_r2 - {1'b0, dsr_q}) : div_r2[17:0];
						dd_q  <= {dd_q[DW-2:0], div_ge};
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						result_q.svm           <= svm_q;
						result_q.angle_x       <= tilt_q;
						result_q.offsets_ready <= ready_flag_q;
						result_q.calib_done    <= done_q;
						result_valid_q         <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
